// File: hdl/bsa_pkg.sv
`default_nettype none

package bsa_pkg;

    localparam int MAX_BITS_DEF    = 64;
    localparam int COUNT_WIDTH_DEF = 48;
    localparam int SUM_BITS        = 64;
    localparam int NIBBLE_DEPTH    = 16;

    localparam logic CMD_ACCUMULATE = 1'b0;
    localparam logic CMD_READ       = 1'b1;

    localparam logic [3:0] TBL_TOTAL   = 4'd0;
    localparam logic [3:0] TBL_SUM_LO  = 4'd1;
    localparam logic [3:0] TBL_SUM_HI  = 4'd2;
    localparam logic [3:0] TBL_PARITY  = 4'd3;
    localparam logic [3:0] TBL_BITVAL  = 4'd4;
    localparam logic [3:0] TBL_WEIGHT  = 4'd5;
    localparam logic [3:0] TBL_CHANGE  = 4'd6;
    localparam logic [3:0] TBL_TOGGLE  = 4'd7;
    localparam logic [3:0] TBL_ZPOS    = 4'd8;
    localparam logic [3:0] TBL_OPOS    = 4'd9;
    localparam logic [3:0] TBL_ZRUN    = 4'd10;
    localparam logic [3:0] TBL_ORUN    = 4'd11;
    localparam logic [3:0] TBL_RUNS    = 4'd12;
    localparam logic [3:0] TBL_NIBBLE  = 4'd13;

    localparam logic REG_BITS_IN_USE = 1'b0;
    localparam logic [6:0] BITS_IN_USE_RESET = 7'd64;

endpackage

`default_nettype wire

// File: hdl/bit_statistics_accumulator.sv
// channel  direction  handshake                      payload
// in       input      i_in_valid / o_in_ready        i_cmd i_word i_table_sel i_entry_index
// out      output     o_out_valid / i_out_ready      o_value
// cfg      input      psel penable pwrite pready     paddr pwdata prdata
//
// an accumulate item walks the masked word one bit per step, each step a read and a
// write state of the counter memories
// a read item passes S_QRD and S_QOUT, then its result loads in S_DONE
// input ready returns as the result loads (S_DONE to S_IDLE): no item is taken before the last result loads
// synchronous active-low reset, then a clearing pass zeroes every address of the counter memories
// a new item is taken while a result still waits; the next result waits for it
`default_nettype none

module bit_statistics_accumulator
    import bsa_pkg::*;
#(
    parameter int MAX_BITS    = MAX_BITS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_cmd,
    input  wire logic [63:0] i_word,
    input  wire logic [3:0]  i_table_sel,
    input  wire logic [6:0]  i_entry_index,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_value,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int HDEPTH = MAX_BITS + 1;
    localparam int MDEPTH = (HDEPTH > NIBBLE_DEPTH) ? HDEPTH : NIBBLE_DEPTH;
    localparam int MAW    = $clog2(MDEPTH);
    localparam int HAW    = $clog2(HDEPTH);
    localparam int IW     = $clog2(SUM_BITS);
    localparam int CW     = COUNT_WIDTH;
    localparam int NMEM   = 9;

    localparam int M_WEIGHT = 0;
    localparam int M_CHANGE = 1;
    localparam int M_TOGGLE = 2;
    localparam int M_ZPOS   = 3;
    localparam int M_OPOS   = 4;
    localparam int M_ZRUN   = 5;
    localparam int M_ORUN   = 6;
    localparam int M_RUNS   = 7;
    localparam int M_NIB    = 8;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_RD,
        S_WR,
        S_FIN_RD,
        S_FIN_WR,
        S_QRD,
        S_QOUT,
        S_DONE
    } t_state;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] x);
        logic [CW-1:0] y;
        y = (&x) ? x : x + 1'b1;
        return y;
    endfunction

    t_state             r_state;
    logic [MAW-1:0]     r_caddr;
    logic [6:0]         r_bits;
    logic [6:0]         r_wid;
    logic [IW-1:0]      r_idx;
    logic [SUM_BITS-1:0] r_us;
    logic [SUM_BITS-1:0] r_ds;
    logic [SUM_BITS-1:0] r_prev;
    logic [SUM_BITS-1:0] r_sl;
    logic [SUM_BITS-1:0] r_sh;
    logic               r_carry;
    logic               r_cur;
    logic [HAW-1:0]     r_run;
    logic [HAW-1:0]     r_runs;
    logic [HAW-1:0]     r_wpop;
    logic [HAW-1:0]     r_dpop;
    logic [CW-1:0]      r_total;
    logic [CW-1:0]      r_par [2];
    logic [CW-1:0]      r_bv  [2];
    logic [3:0]         r_tsel;
    logic [6:0]         r_eidx;
    logic [63:0]        r_res;
    logic               r_ovld;
    logic [63:0]        r_oval;
    logic [NMEM-1:0]    r_inc;

    logic [CW-1:0]      r_mem   [NMEM][MDEPTH];
    logic [CW-1:0]      r_rdata [NMEM];
    logic [MAW-1:0]     r_waddr [NMEM];

    logic [MAW-1:0]     n_addr [NMEM];
    logic [NMEM-1:0]    n_inc;
    logic [CW-1:0]      n_eff  [NMEM];
    logic [6:0]         n_wid;
    logic [SUM_BITS-1:0] n_mask;
    logic [SUM_BITS-1:0] n_u;
    logic               n_b;
    logic               n_db;
    logic               n_act;
    logic               n_brk;
    logic               n_s;
    logic [63:0]        n_rd;
    logic               in_xfer;
    logic               cfg_wr;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovld;
    assign o_value     = r_oval;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite && (paddr == {REG_BITS_IN_USE, 2'b00});
    assign prdata      = (paddr == {REG_BITS_IN_USE, 2'b00}) ? {25'd0, r_bits} : 32'd0;

    always_comb begin
        if (r_bits == 7'd0) begin
            n_wid = 7'd1;
        end else if (r_bits > 7'(MAX_BITS)) begin
            n_wid = 7'(MAX_BITS);
        end else begin
            n_wid = r_bits;
        end
        for (int j = 0; j < SUM_BITS; j++) begin
            n_mask[j] = (7'(j) < n_wid);
        end
        n_u   = i_word & n_mask;
        n_b   = r_us[0];
        n_db  = r_ds[0];
        n_act = ({1'b0, r_idx} < r_wid);
        n_brk = n_act && (n_b != r_cur);
        n_s   = r_sl[0] ^ n_b ^ r_carry;
    end

    always_comb begin
        for (int k = 0; k < NMEM; k++) begin
            n_addr[k] = '0;
            n_eff[k]  = r_rdata[k];
        end
        n_inc = '0;
        unique case (r_state)
            S_RD: begin
                n_addr[M_TOGGLE] = MAW'(r_idx);
                n_addr[M_ZPOS]   = MAW'(r_idx);
                n_addr[M_OPOS]   = MAW'(r_idx);
                n_addr[M_NIB]    = MAW'(r_us[3:0]);
                n_addr[M_ZRUN]   = MAW'(r_run);
                n_addr[M_ORUN]   = MAW'(r_run);
                n_inc[M_TOGGLE]  = n_act && n_db;
                n_inc[M_ZPOS]    = n_act && !n_b;
                n_inc[M_OPOS]    = n_act && n_b;
                n_inc[M_NIB]     = n_act && (r_idx[1:0] == 2'd0);
                n_inc[M_ZRUN]    = n_brk && !r_cur;
                n_inc[M_ORUN]    = n_brk && r_cur;
            end
            S_FIN_RD: begin
                n_addr[M_WEIGHT] = MAW'(r_wpop);
                n_addr[M_CHANGE] = MAW'(r_dpop);
                n_addr[M_RUNS]   = MAW'(r_runs);
                n_addr[M_ZRUN]   = MAW'(r_run);
                n_addr[M_ORUN]   = MAW'(r_run);
                n_inc[M_WEIGHT]  = 1'b1;
                n_inc[M_CHANGE]  = 1'b1;
                n_inc[M_RUNS]    = 1'b1;
                n_inc[M_ZRUN]    = !r_cur;
                n_inc[M_ORUN]    = r_cur;
            end
            S_QRD: begin
                for (int k = 0; k < NMEM; k++) begin
                    n_addr[k] = MAW'(r_eidx);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_rd = '0;
        unique case (r_tsel)
            TBL_TOTAL:  n_rd = (r_eidx == 7'd0) ? 64'(r_total) : '0;
            TBL_SUM_LO: n_rd = (r_eidx == 7'd0) ? r_sl : '0;
            TBL_SUM_HI: n_rd = (r_eidx == 7'd0) ? r_sh : '0;
            TBL_PARITY: n_rd = (r_eidx < 7'd2) ? 64'(r_par[r_eidx[0]]) : '0;
            TBL_BITVAL: n_rd = (r_eidx < 7'd2) ? 64'(r_bv[r_eidx[0]]) : '0;
            TBL_WEIGHT: n_rd = (r_eidx < HDEPTH) ? 64'(n_eff[M_WEIGHT]) : '0;
            TBL_CHANGE: n_rd = (r_eidx < HDEPTH) ? 64'(n_eff[M_CHANGE]) : '0;
            TBL_TOGGLE: n_rd = (r_eidx < MAX_BITS) ? 64'(n_eff[M_TOGGLE]) : '0;
            TBL_ZPOS:   n_rd = (r_eidx < MAX_BITS) ? 64'(n_eff[M_ZPOS]) : '0;
            TBL_OPOS:   n_rd = (r_eidx < MAX_BITS) ? 64'(n_eff[M_OPOS]) : '0;
            TBL_ZRUN:   n_rd = (r_eidx < HDEPTH) ? 64'(n_eff[M_ZRUN]) : '0;
            TBL_ORUN:   n_rd = (r_eidx < HDEPTH) ? 64'(n_eff[M_ORUN]) : '0;
            TBL_RUNS:   n_rd = (r_eidx < HDEPTH) ? 64'(n_eff[M_RUNS]) : '0;
            TBL_NIBBLE: n_rd = (r_eidx < NIBBLE_DEPTH) ? 64'(n_eff[M_NIB]) : '0;
            default:    n_rd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_caddr <= '0;
            r_bits  <= BITS_IN_USE_RESET;
            r_ovld  <= 1'b0;
            r_inc   <= '0;
            r_total <= '0;
            r_par   <= '{default: '0};
            r_bv    <= '{default: '0};
            r_sl    <= '0;
            r_sh    <= '0;
            r_prev  <= '0;
        end else begin
            r_inc <= n_inc;
            if (cfg_wr) begin
                r_bits <= pwdata[6:0];
            end
            if (r_ovld && i_out_ready && (r_state != S_DONE)) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_caddr <= r_caddr + 1'b1;
                    if (r_caddr == MAW'(MDEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        r_tsel <= i_table_sel;
                        r_eidx <= i_entry_index;
                        if (i_cmd == CMD_READ) begin
                            r_state <= S_QRD;
                        end else begin
                            r_us    <= n_u;
                            r_ds    <= n_u ^ r_prev;
                            r_prev  <= n_u;
                            r_wid   <= n_wid;
                            r_cur   <= n_u[0];
                            r_run   <= '0;
                            r_runs  <= HAW'(1);
                            r_wpop  <= '0;
                            r_dpop  <= '0;
                            r_carry <= 1'b0;
                            r_idx   <= '0;
                            r_total <= sat_inc(r_total);
                            r_par[n_u[0]] <= sat_inc(r_par[n_u[0]]);
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_us    <= r_us >> 1;
                    r_ds    <= r_ds >> 1;
                    r_sl    <= {n_s, r_sl[SUM_BITS-1:1]};
                    r_carry <= (r_sl[0] & n_b) | (r_sl[0] & r_carry) | (n_b & r_carry);
                    r_wpop  <= r_wpop + HAW'(n_b);
                    r_dpop  <= r_dpop + HAW'(n_db);
                    if (n_act) begin
                        r_bv[n_b] <= sat_inc(r_bv[n_b]);
                        if (n_brk) begin
                            r_cur  <= n_b;
                            r_run  <= HAW'(1);
                            r_runs <= r_runs + 1'b1;
                        end else begin
                            r_run <= r_run + 1'b1;
                        end
                    end
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_idx <= r_idx + 1'b1;
                    r_state <= (&r_idx) ? S_FIN_RD : S_RD;
                end
                S_FIN_RD: begin
                    if (r_carry) begin
                        if (&r_sh) begin
                            r_sl <= '1;
                        end else begin
                            r_sh <= r_sh + 1'b1;
                        end
                    end
                    r_state <= S_FIN_WR;
                end
                S_FIN_WR: begin
                    r_res   <= '0;
                    r_state <= S_DONE;
                end
                S_QRD: begin
                    r_state <= S_QOUT;
                end
                S_QOUT: begin
                    r_res   <= n_rd;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovld || i_out_ready) begin
                        r_oval  <= r_res;
                        r_ovld  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NMEM; k++) begin
            r_rdata[k] <= r_mem[k][n_addr[k]];
            r_waddr[k] <= n_addr[k];
            if (r_state == S_CLR) begin
                r_mem[k][r_caddr] <= '0;
            end else if ((r_state == S_WR || r_state == S_FIN_WR) && r_inc[k]) begin
                r_mem[k][r_waddr[k]] <= sat_inc(r_rdata[k]);
            end
        end
    end

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside done state");

    a_step_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WR |=> r_state == S_RD || r_state == S_FIN_RD)
        else $error("bit step out of order");

    a_read_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_QOUT |-> r_inc == '0)
        else $error("counter update during read transfer");

endmodule

`default_nettype wire
